FILE: rtl/core/hkv_pkg.sv
// Package for the hashed key-value table: request and response types,
// command, status and configuration register codes.
// No dependencies.
package hkv_pkg;

  localparam int unsigned OpcodeW  = 2;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned BucketW  = 6;
  localparam int unsigned KlenW    = 4;
  localparam int unsigned TsizeW   = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;
  // A byte sum of up to eight bytes fits in 11 bits.
  localparam int unsigned SumW     = 11;

  localparam logic [OpcodeW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpcodeW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpcodeW-1:0] OP_LOOKUP = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_KLEN  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TSIZE = 2'd1;

  localparam logic [KlenW-1:0]  KLEN_RESET  = 4'd8;
  localparam logic [TsizeW-1:0] TSIZE_RESET = 7'd64;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [KeyW-1:0]    key;
    logic [ValueW-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value_out;
    logic [BucketW-1:0] bucket;
  } rsp_t;

endpackage

FILE: rtl/core/hkv_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module hkv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/hashed_key_value_table.sv
// Key-value table for text keys of up to eight bytes. After reset the block
// runs a clearing pass over the valid bits, one bucket per cycle, and takes
// no request meanwhile. For a request, one shared adder first sums the key
// bytes one per cycle, then works out the 11-bit sum modulo the table size
// one bit per cycle, and the bucket's ways are then read from the entry RAM
// one per cycle. One request is in work at a time; the response register
// lets the next request in while a response still waits.
// Depends on hkv_pkg and hkv_ram.
module hashed_key_value_table #(
  parameter int unsigned BUCKETS   = 64,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  hkv_pkg::req_t                 req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output hkv_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hkv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hkv_pkg::CfgDataW-1:0]  cfg_data_i
);

  import hkv_pkg::*;

  localparam int unsigned Entries = BUCKETS * WAYS;
  localparam int unsigned BktW    = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int unsigned AddrW   = Entries > 1 ? $clog2(Entries) : 1;
  localparam int unsigned WayW    = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int unsigned KW      = 8 * KEY_BYTES;
  localparam int unsigned EntryW  = KW + ValueW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_VRD   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_ACT   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [KlenW-1:0]    klen_q, klen_d;
  logic [TsizeW-1:0]   tsize_q, tsize_d;
  logic [BktW-1:0]     clr_q, clr_d;
  logic [OpcodeW-1:0]  op_q, op_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [ValueW-1:0]   val_q, val_d;
  logic [KeyW-1:0]     norm_q, norm_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [3:0]          cnt_q, cnt_d;
  logic [TsizeW-1:0]   rem_q, rem_d;
  logic [WayW-1:0]     way_q, way_d;
  logic                hit_q, hit_d;
  logic [WayW-1:0]     hit_way_q, hit_way_d;
  logic                free_q, free_d;
  logic [WayW-1:0]     free_way_q, free_way_d;
  rsp_t                res_q, res_d;
  rsp_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [KlenW-1:0]    klen_eff;
  logic [TsizeW-1:0]   tsize_eff;
  logic [7:0]          cur_byte;
  logic [TsizeW:0]     rem_sh;

  // Shared adder: byte accumulation, and compare-subtract for the modulo.
  logic [SumW-1:0]     alu_a, alu_b;
  logic                alu_cin;
  logic [SumW:0]       alu_res;

  logic                vram_we, vram_re;
  logic [BktW-1:0]     vram_waddr, vram_raddr;
  logic [WAYS-1:0]     vram_wdata, vram_rdata;
  logic                eram_we, eram_re;
  logic [AddrW-1:0]    eram_waddr, eram_raddr;
  logic [EntryW-1:0]   eram_wdata, eram_rdata;
  logic [BktW-1:0]     bucket_idx;

  always_comb begin
    if (klen_q == '0) begin
      klen_eff = KlenW'(1);
    end else if (32'(klen_q) > KEY_BYTES) begin
      klen_eff = KlenW'(KEY_BYTES);
    end else begin
      klen_eff = klen_q;
    end
    if (tsize_q == '0) begin
      tsize_eff = TsizeW'(1);
    end else if (32'(tsize_q) > BUCKETS) begin
      tsize_eff = TsizeW'(BUCKETS);
    end else begin
      tsize_eff = tsize_q;
    end
  end

  assign cur_byte   = key_q[{cnt_q[2:0], 3'b000} +: 8];
  assign rem_sh     = {rem_q, sum_q[SumW-1]};
  assign bucket_idx = BktW'(rem_q);
  assign alu_res    = {1'b0, alu_a} + {1'b0, alu_b} + (SumW+1)'(alu_cin);

  always_comb begin
    if (state_q == S_MOD) begin
      alu_a   = SumW'(rem_sh);
      alu_b   = ~SumW'(tsize_eff);
      alu_cin = 1'b1;
    end else begin
      alu_a   = sum_q;
      alu_b   = SumW'(cur_byte);
      alu_cin = 1'b0;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  always_comb begin
    state_d     = state_q;
    klen_d      = klen_q;
    tsize_d     = tsize_q;
    clr_d       = clr_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    norm_d      = norm_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    way_d       = way_q;
    hit_d       = hit_q;
    hit_way_d   = hit_way_q;
    free_d      = free_q;
    free_way_d  = free_way_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    vram_we    = 1'b0;
    vram_waddr = bucket_idx;
    vram_wdata = vram_rdata;
    vram_re    = 1'b0;
    vram_raddr = bucket_idx;
    eram_we    = 1'b0;
    eram_waddr = AddrW'(32'(bucket_idx) * WAYS + 32'(way_q));
    eram_wdata = {val_q, norm_q[KW-1:0]};
    eram_re    = 1'b0;
    eram_raddr = AddrW'(32'(bucket_idx) * WAYS + 32'(way_q));

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KLEN:  klen_d  = cfg_data_i[KlenW-1:0];
        REG_TSIZE: tsize_d = cfg_data_i[TsizeW-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        vram_we    = 1'b1;
        vram_waddr = clr_q;
        vram_wdata = '0;
        clr_d      = clr_q + BktW'(1);
        if (clr_q == BktW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_i.opcode;
          key_d   = req_i.key;
          val_d   = req_i.value;
          norm_d  = '0;
          sum_d   = '0;
          cnt_d   = '0;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        // The key ends at its first zero byte or at the key length.
        if (cnt_q == klen_eff || cur_byte == 8'd0) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = S_MOD;
        end else begin
          sum_d = alu_res[SumW-1:0];
          norm_d[{cnt_q[2:0], 3'b000} +: 8] = cur_byte;
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_MOD: begin
        // Restoring remainder, one dividend bit per cycle; the carry out
        // says the shifted remainder is not below the table size.
        if (alu_res[SumW]) begin
          rem_d = alu_res[TsizeW-1:0];
        end else begin
          rem_d = rem_sh[TsizeW-1:0];
        end
        sum_d = {sum_q[SumW-2:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(SumW - 1)) begin
          state_d = S_VRD;
        end
      end
      S_VRD: begin
        vram_re    = 1'b1;
        eram_re    = 1'b1;
        eram_raddr = AddrW'(32'(bucket_idx) * WAYS);
        way_d      = '0;
        hit_d      = 1'b0;
        free_d     = 1'b0;
        state_d    = S_CMP;
      end
      S_CMP: begin
        if (vram_rdata[way_q] && eram_rdata[KW-1:0] == norm_q[KW-1:0]) begin
          hit_d     = 1'b1;
          hit_way_d = way_q;
          state_d   = S_ACT;
        end else begin
          if (!vram_rdata[way_q] && !free_q) begin
            free_d     = 1'b1;
            free_way_d = way_q;
          end
          if (way_q == WayW'(WAYS - 1)) begin
            state_d = S_ACT;
          end else begin
            way_d      = way_q + WayW'(1);
            eram_re    = 1'b1;
            eram_raddr = AddrW'(32'(bucket_idx) * WAYS + 32'(way_q) + 1);
          end
        end
      end
      S_ACT: begin
        res_d.status    = ST_NOT_FOUND;
        res_d.value_out = '0;
        res_d.bucket    = BucketW'(rem_q);
        if (op_q == OP_INSERT) begin
          if (hit_q) begin
            eram_we      = 1'b1;
            eram_waddr   = AddrW'(32'(bucket_idx) * WAYS + 32'(hit_way_q));
            res_d.status = ST_OK;
          end else if (free_q) begin
            eram_we      = 1'b1;
            eram_waddr   = AddrW'(32'(bucket_idx) * WAYS + 32'(free_way_q));
            vram_we      = 1'b1;
            vram_wdata   = vram_rdata | (WAYS'(1) << free_way_q);
            res_d.status = ST_OK;
          end else begin
            res_d.status = ST_FULL;
          end
        end else if (op_q == OP_DELETE) begin
          if (hit_q) begin
            vram_we      = 1'b1;
            vram_wdata   = vram_rdata & ~(WAYS'(1) << hit_way_q);
            res_d.status = ST_OK;
          end
        end else begin
          // Lookup; the unused opcode behaves the same. The hit way's data
          // is still on the read port since the search stopped there.
          if (hit_q) begin
            res_d.status    = ST_OK;
            res_d.value_out = eram_rdata[KW +: ValueW];
          end
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      klen_q      <= KLEN_RESET;
      tsize_q     <= TSIZE_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      klen_q      <= klen_d;
      tsize_q     <= tsize_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      way_q       <= way_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    norm_q     <= norm_d;
    sum_q      <= sum_d;
    rem_q      <= rem_d;
    hit_way_q  <= hit_way_d;
    free_way_q <= free_way_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  hkv_ram #(
    .Width (WAYS),
    .Depth (BUCKETS)
  ) u_valid_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .re_i    (vram_re),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  hkv_ram #(
    .Width (EntryW),
    .Depth (Entries)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (eram_we),
    .waddr_i (eram_waddr),
    .wdata_i (eram_wdata),
    .re_i    (eram_re),
    .raddr_i (eram_raddr),
    .rdata_o (eram_rdata)
  );

endmodule

FILE: verif/tb_hashed_key_value_table.sv
// Self-checking testbench for hashed_key_value_table: random and directed insert, delete and
// lookup requests under several key length and table size settings, checked by a local model.
// Depends on hkv_pkg and the hashed_key_value_table RTL.
module tb_hashed_key_value_table;
  import hkv_pkg::*;

  localparam int BUCKETS   = 64;
  localparam int WAYS      = 4;
  localparam int KEY_BYTES = 8;
  localparam int ENTRIES   = BUCKETS * WAYS;
  localparam int PHASES    = 12;
  localparam int PHASE_REQUESTS = 52;

  // Opcode three has no name in the package; the block decodes it as a lookup.
  localparam logic [OpcodeW-1:0] OP_SPARE = 2'd3;
  // Register indexes with no register behind them.
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  class kv_checker;
    logic [KeyW-1:0]    slot_key [ENTRIES];
    logic [ValueW-1:0]  slot_value [ENTRIES];
    bit                 slot_used [ENTRIES];
    logic [KlenW-1:0]   klen_cfg;
    logic [TsizeW-1:0]  tsize_cfg;
    rsp_t               awaited_rsp_q [$];
    int                 failures;
    int                 commands;
    int                 found;
    int                 missed;
    int                 full_count;
    int                 reg_writes;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      klen_cfg   = KLEN_RESET;
      tsize_cfg  = TSIZE_RESET;
      failures   = 0;
      commands   = 0;
      found      = 0;
      missed     = 0;
      full_count = 0;
      reg_writes = 0;
    endfunction

    function int key_bytes();
      if (klen_cfg == 0) return 1;
      if (klen_cfg > KEY_BYTES) return KEY_BYTES;
      return int'(klen_cfg);
    endfunction

    function int buckets_in_use();
      if (tsize_cfg == 0) return 1;
      if (tsize_cfg > BUCKETS) return BUCKETS;
      return int'(tsize_cfg);
    endfunction

    function int awaited();
      return awaited_rsp_q.size();
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      reg_writes++;
      if (idx == REG_KLEN) klen_cfg = data[KlenW-1:0];
      else if (idx == REG_TSIZE) tsize_cfg = data[TsizeW-1:0];
    endfunction

    // Works out the response to one accepted request and updates the stored entries.
    function void apply_command(req_t r);
      logic [KeyW-1:0] norm;
      int              sum;
      int              len;
      int              bkt;
      int              base;
      int              hit;
      int              free_way;
      bit              ended;
      rsp_t            exp;
      norm  = '0;
      sum   = 0;
      ended = 1'b0;
      len   = key_bytes();
      for (int i = 0; i < KEY_BYTES; i++) begin
        if (i < len && !ended) begin
          if (r.key[8*i +: 8] == 8'h00) begin
            ended = 1'b1;
          end else begin
            norm[8*i +: 8] = r.key[8*i +: 8];
            sum += r.key[8*i +: 8];
          end
        end
      end
      bkt      = sum % buckets_in_use();
      base     = bkt * WAYS;
      hit      = -1;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (slot_used[base + w]) begin
          if (hit < 0 && slot_key[base + w] == norm) hit = w;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      exp.status    = ST_NOT_FOUND;
      exp.value_out = '0;
      exp.bucket    = bkt[BucketW-1:0];
      case (r.opcode)
        OP_INSERT: begin
          if (hit >= 0) begin
            slot_value[base + hit] = r.value;
            exp.status = ST_OK;
          end else if (free_way >= 0) begin
            slot_key[base + free_way]   = norm;
            slot_value[base + free_way] = r.value;
            slot_used[base + free_way]  = 1'b1;
            exp.status = ST_OK;
          end else begin
            exp.status = ST_FULL;
          end
        end
        OP_DELETE: begin
          if (hit >= 0) begin
            slot_used[base + hit] = 1'b0;
            exp.status = ST_OK;
          end
        end
        default: begin
          if (hit >= 0) begin
            exp.value_out = slot_value[base + hit];
            exp.status    = ST_OK;
          end
        end
      endcase
      commands++;
      if (exp.status == ST_OK) found++;
      else if (exp.status == ST_FULL) full_count++;
      else missed++;
      awaited_rsp_q.push_back(exp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (awaited_rsp_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: response with none outstanding: status %0d value_out %h bucket %0d",
                   $time, got.status, got.value_out, got.bucket);
        return;
      end
      exp = awaited_rsp_q.pop_front();
      if (got.status !== exp.status || got.value_out !== exp.value_out ||
          got.bucket !== exp.bucket) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: status %0d/%0d value_out %h/%h bucket %0d/%0d (exp/got)",
                   $time, exp.status, got.status, exp.value_out, got.value_out,
                   exp.bucket, got.bucket);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                req_valid = 1'b0;
  logic                req_ready;
  req_t                req = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  rsp_t                rsp;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  kv_checker           sb;
  logic [KeyW-1:0]     key_pool [16];
  int                  pool_len [16];
  bit                  req_quiet = 1'b0;
  bit                  rsp_quiet = 1'b0;

  hashed_key_value_table #(
    .BUCKETS  (BUCKETS),
    .WAYS     (WAYS),
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (req_valid && req_ready) sb.apply_command(req);
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
    end
  end

  // Mostly short gaps, a few long ones; none at all when quiet.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : rsp_ready_drive
    int n;
    @(posedge rst_n);
    forever begin
      n = pick_gap(rsp_quiet);
      if (n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_command(input req_t cmd, input int gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= cmd;
    do @(posedge clk); while (!req_ready);
  endtask

  // Waiting for a clock edge first lets the monitor note the last accepted request before the count is read.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited() > 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t cmd(logic [OpcodeW-1:0] op, logic [KeyW-1:0] key,
                               logic [ValueW-1:0] value);
    req_t c;
    c.opcode = op;
    c.key    = key;
    c.value  = value;
    return c;
  endfunction

  // The first half of the pool are rotations of one key, so they share a bucket and fill it.
  function automatic void fill_pool();
    logic [KeyW-1:0] base;
    int              len;
    base = '0;
    len  = $urandom_range(1, KEY_BYTES);
    for (int i = 0; i < len; i++) base[8*i +: 8] = 8'($urandom_range(1, 255));
    for (int j = 0; j < 8; j++) begin
      key_pool[j] = '0;
      pool_len[j] = len;
      for (int i = 0; i < len; i++) key_pool[j][8*i +: 8] = base[8*((i + j) % len) +: 8];
    end
    for (int j = 8; j < 16; j++) begin
      key_pool[j] = '0;
      pool_len[j] = $urandom_range(1, KEY_BYTES);
      for (int i = 0; i < pool_len[j]; i++) key_pool[j][8*i +: 8] = 8'($urandom_range(1, 255));
    end
  endfunction

  function automatic logic [KeyW-1:0] make_key();
    logic [KeyW-1:0] k;
    int              sel;
    int              idx;
    int              from;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      idx = $urandom_range(0, 15);
      k   = key_pool[idx];
      // Garbage past the terminator or past the key length must not change the key.
      if ($urandom_range(0, 1)) begin
        from = (pool_len[idx] < sb.key_bytes()) ? pool_len[idx] + 1 : sb.key_bytes();
        for (int i = from; i < KEY_BYTES; i++) k[8*i +: 8] = 8'($urandom_range(0, 255));
      end
    end else if (sel < 82) begin
      k = {$urandom, $urandom};
    end else if (sel < 92) begin
      k   = {$urandom, $urandom};
      idx = $urandom_range(0, KEY_BYTES - 1);
      k[8*idx +: 8] = 8'h00;
    end else if (sel < 96) begin
      k = '0;
    end else begin
      k = '1;
    end
    return k;
  endfunction

  function automatic req_t make_command();
    req_t c;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 40) c.opcode = OP_INSERT;
    else if (r < 70) c.opcode = OP_LOOKUP;
    else if (r < 92) c.opcode = OP_DELETE;
    else c.opcode = OP_SPARE;
    c.key = make_key();
    r = $urandom_range(0, 19);
    if (r == 0) c.value = '0;
    else if (r == 1) c.value = '1;
    else c.value = $urandom;
    return c;
  endfunction

  initial begin : stimulus
    req_t                directed [$];
    logic [CfgDataW-1:0] klen_list [8];
    logic [CfgDataW-1:0] tsize_list [8];
    logic [CfgDataW-1:0] klen_data;
    logic [CfgDataW-1:0] tsize_data;
    int                  pause_at;
    sb = new();
    klen_list  = '{7'd8, 7'd1, 7'd8, 7'd2, 7'd0, 7'd15, 7'd4, 7'd9};
    tsize_list = '{7'd64, 7'd1, 7'd1, 7'd5, 7'd0, 7'd127, 7'd64, 7'd65};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_register(REG_KLEN, CfgDataW'(KLEN_RESET));
    write_register(REG_TSIZE, TSIZE_RESET);

    // Empty key, and a key whose first byte is zero with garbage above it.
    directed.push_back(cmd(OP_LOOKUP, 64'h0, 32'h1234_5678));
    directed.push_back(cmd(OP_DELETE, 64'h0, 32'h0));
    directed.push_back(cmd(OP_INSERT, 64'h0, 32'hFFFF_FFFF));
    directed.push_back(cmd(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 32'h0));
    // Largest byte sum, value zero, opcode three, delete and miss.
    directed.push_back(cmd(OP_INSERT, '1, 32'h0));
    directed.push_back(cmd(OP_LOOKUP, '1, 32'hFFFF_FFFF));
    directed.push_back(cmd(OP_SPARE, '1, 32'h0));
    directed.push_back(cmd(OP_DELETE, '1, 32'h0));
    directed.push_back(cmd(OP_LOOKUP, '1, 32'h0));
    directed.push_back(cmd(OP_DELETE, '1, 32'h0));
    // Anagrams of "abc" share one bucket: four fill it, the fifth finds it full.
    directed.push_back(cmd(OP_INSERT, 64'h63_6261, $urandom));
    directed.push_back(cmd(OP_INSERT, 64'h62_6361, $urandom));
    directed.push_back(cmd(OP_INSERT, 64'h63_6162, $urandom));
    directed.push_back(cmd(OP_INSERT, 64'h61_6362, $urandom));
    directed.push_back(cmd(OP_INSERT, 64'h62_6163, $urandom));
    directed.push_back(cmd(OP_INSERT, 64'h63_6261, 32'hA5A5_5A5A));
    directed.push_back(cmd(OP_LOOKUP, 64'h63_6261, 32'h0));
    directed.push_back(cmd(OP_DELETE, 64'h63_6162, 32'h0));
    directed.push_back(cmd(OP_INSERT, 64'h62_6163, 32'h0BAD_CAFE));
    directed.push_back(cmd(OP_LOOKUP, 64'h62_6163, 32'h0));
    directed.push_back(cmd(OP_LOOKUP, 64'h63_6162, 32'h0));
    // Bytes after the terminator are not part of the key, so this replaces "abc".
    directed.push_back(cmd(OP_INSERT, 64'h0000_7A7A_0063_6261, 32'h5555_AAAA));
    directed.push_back(cmd(OP_LOOKUP, 64'h63_6261, 32'h0));
    foreach (directed[i]) send_command(directed[i], pick_gap(1'b0));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 8) begin
        klen_data  = klen_list[phase];
        tsize_data = tsize_list[phase];
      end else begin
        klen_data  = CfgDataW'($urandom_range(0, 127));
        tsize_data = CfgDataW'($urandom_range(0, 127));
      end
      write_register(REG_KLEN, klen_data);
      write_register(REG_TSIZE, tsize_data);
      if (phase == 5) begin
        write_register(REG_SPARE_A, CfgDataW'($urandom_range(0, 127)));
        write_register(REG_SPARE_B, CfgDataW'($urandom_range(0, 127)));
      end
      if (phase == 0 || $urandom_range(0, 2) != 0) fill_pool();
      req_quiet = (phase % 4 == 1);
      rsp_quiet = (phase % 4 == 1) || (phase % 4 == 3);
      pause_at  = $urandom_range(10, 40);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        // Hold requests back once per setting until the block has answered everything.
        if (i == pause_at) drain();
        send_command(make_command(), pick_gap(req_quiet));
      end
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Sent %0d requests over %0d register writes: %0d succeeded, %0d missed, %0d full.",
             sb.commands, sb.reg_writes, sb.found, sb.missed, sb.full_count);
    $display("Covered empty and cut keys, replacement, full buckets and out-of-range settings.");
    if (sb.failures == 0 && sb.awaited() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
